/* rtl/core/mlp_ff_pkg.sv */
// Shared types, codes and activation tables for the feed-forward network block.
`timescale 1ns / 1ps

package mlp_ff_pkg;

   localparam int MAX_WIDTH_DEF  = 16;
   localparam int MAX_HIDDEN_DEF = 4;

   // Widest activation buffer address over the whole parameter range.
   localparam int ABUF_ADDR_MAX_W = 9;

   localparam logic OP_WEIGHT = 1'b0;
   localparam logic OP_DATA   = 1'b1;

   localparam logic [1:0] ACT_SIGMOID = 2'd0;
   localparam logic [1:0] ACT_RELU    = 2'd1;
   localparam logic [1:0] ACT_TANH    = 2'd2;

   localparam logic [2:0] CSR_ACT_MODE = 3'd0;
   localparam logic [2:0] CSR_INPUTS   = 3'd1;
   localparam logic [2:0] CSR_HIDDEN   = 3'd2;
   localparam logic [2:0] CSR_PER_HID  = 3'd3;
   localparam logic [2:0] CSR_OUTPUTS  = 3'd4;

   typedef struct packed {
      logic              operation;
      logic [2:0]        layer_index;
      logic [3:0]        neuron_index;
      logic [3:0]        source_index;
      logic signed [15:0] value;
      logic              last;
   } req_item_type;

   typedef struct packed {
      logic [3:0]         output_index;
      logic signed [15:0] output_value;
      logic               last_output;
      logic               no_weights;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] act_mode;
      logic [4:0] n_in;
      logic [2:0] hidden;
      logic [4:0] per;
      logic [4:0] outs;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ERROR,
      ST_LAYER,
      ST_START,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic                       clear_en;
      logic [ABUF_ADDR_MAX_W-1:0] clear_addr;
      logic                       req_accept;
      logic                       acc_clear;
      logic                       issue;
      logic [2:0]                 rd_layer;
      logic [4:0]                 rd_neuron;
      logic [4:0]                 rd_src;
      logic                       rd_half;
      logic                       wr_act;
      logic                       wr_half;
      logic [4:0]                 wr_neuron;
      logic                       load_rsp;
      logic                       rsp_last;
      logic                       load_err;
   } ctl_cmd_type;

   typedef struct packed {
      logic mac_idle;
      logic rsp_free;
      logic weights_written;
   } dp_status_type;

   typedef logic [255:0][15:0] rom_type;

   // Bit-serial long division, used only while building the tables.
   function automatic logic [63:0] udiv_const(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Entry i stands for x = (i-128)/16; exp steps are e^(1/16) in Q24.
   function automatic rom_type build_rom(input logic tanh_sel);
      logic [63:0] e_tab [129];
      logic [63:0] e_val;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] r_val;
      logic [63:0] d_val;
      logic [63:0] t_val;
      logic [15:0] entry;
      rom_type     rom;
      int          k;
      e_tab[0] = 64'd16777216;
      for (int i = 1; i <= 128; i++) begin
         e_tab[i] = (e_tab[i-1] * 64'd17859253 + 64'd8388608) >> 24;
      end
      for (int i = 0; i < 256; i++) begin
         k     = i - 128;
         e_val = e_tab[(k < 0) ? -k : k];
         if (tanh_sel) begin
            r_val = udiv_const((64'd1 << 48) + (e_val >> 1), e_val);
            d_val = e_val + r_val;
            t_val = udiv_const(((e_val - r_val) << 9) + d_val, d_val << 1);
            entry = (k < 0) ? 16'(-t_val) : t_val[15:0];
         end else begin
            den   = e_val + 64'd16777216;
            num   = (k >= 0) ? (e_val << 8) : (64'd1 << 32);
            t_val = udiv_const((num << 1) + den, den << 1);
            entry = t_val[15:0];
         end
         rom[i] = entry;
      end
      return rom;
   endfunction

   localparam rom_type SIG_ROM  = build_rom(1'b0);
   localparam rom_type TANH_ROM = build_rom(1'b1);

   function automatic logic signed [15:0] activate(input logic [1:0] mode,
                                                   input logic signed [15:0] s);
      logic [11:0] u;
      logic [7:0]  idx;
      logic signed [15:0] res;
      u = {~s[15], s[14:4]};
      if (u < 12'd1920) begin
         idx = 8'd0;
      end else if (u > 12'd2175) begin
         idx = 8'd255;
      end else begin
         idx = 8'(u - 12'd1920);
      end
      case (mode)
         ACT_RELU: res = (s > 16'sd0) ? s : 16'sd0;
         ACT_TANH: res = TANH_ROM[idx];
         default:  res = SIG_ROM[idx];
      endcase
      return res;
   endfunction

endpackage

/* rtl/core/mlp_feed_forward_top.sv */
// Top level of the bias-free fully connected network engine.
`timescale 1ns / 1ps

// Runs a bias-free multilayer perceptron in signed Q8.8. Weight items
// (operation 0) write one weight into the store at layer, neuron and source;
// data items (operation 1) drop an input element into the input buffer, and the
// one marked last starts a run through every configured hidden layer and then
// the output layer, one result item per output neuron in neuron order. Each
// neuron sums exact products, shifts right by 8, saturates to 16 bits and goes
// through relu, or a 256-entry sigmoid or tanh table over [-8, 8). A run before
// any weight was written gives a single result item with no_weights set.
// A run visits each neuron of each layer in turn, and its length grows with n,
// that layer's fan-in, since one multiply-accumulate unit reads one weight and
// one activation per cycle from memories with one read port each; an output
// neuron also waits while an earlier result item is still stalled. After reset
// the activation buffers are cleared, and no item is taken meanwhile.
// Configuration registers are to be written by the user only while the block
// is idle; the block itself does not enforce this.

module mlp_feed_forward_top
   import mlp_ff_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HIDDEN = MAX_HIDDEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [4:0]   csr_wdata
);

   cfg_type       cfg;
   ctl_cmd_type   cmd;
   dp_status_type status;

   // Clamp the register values once, so the sequencer sees legal counts.
   mlp_ff_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HIDDEN (MAX_HIDDEN)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer: owns the input handshake and walks layers and neurons.
   mlp_ff_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .cfg       (cfg),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: memories, multiply-accumulate, activation and the result register.
   mlp_ff_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HIDDEN (MAX_HIDDEN)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .act_mode  (cfg.act_mode),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

/* rtl/core/mlp_ff_csr.sv */
// Configuration registers with count clamping.
`timescale 1ns / 1ps

module mlp_ff_csr
   import mlp_ff_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HIDDEN = MAX_HIDDEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [4:0] csr_wdata,
   output cfg_type    cfg
);

   localparam int OUT_LIM = (MAX_WIDTH < 16) ? MAX_WIDTH : 16;

   logic [1:0] mode_ff;
   logic [4:0] inputs_ff;
   logic [2:0] hidden_ff;
   logic [4:0] per_ff;
   logic [4:0] outs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ACT_SIGMOID;
         inputs_ff <= 5'd16;
         hidden_ff <= 3'd1;
         per_ff    <= 5'd16;
         outs_ff   <= 5'd16;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACT_MODE: mode_ff   <= csr_wdata[1:0];
            CSR_INPUTS:   inputs_ff <= csr_wdata;
            CSR_HIDDEN:   hidden_ff <= csr_wdata[2:0];
            CSR_PER_HID:  per_ff    <= csr_wdata;
            CSR_OUTPUTS:  outs_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.act_mode = mode_ff;
      cfg.n_in     = (int'(inputs_ff) > MAX_WIDTH) ? 5'(MAX_WIDTH) : inputs_ff;
      cfg.hidden   = (int'(hidden_ff) > MAX_HIDDEN) ? 3'(MAX_HIDDEN) : hidden_ff;
      cfg.per      = (int'(per_ff) > MAX_WIDTH) ? 5'(MAX_WIDTH) : per_ff;
      cfg.outs     = (int'(outs_ff) > OUT_LIM) ? 5'(OUT_LIM) : outs_ff;
   end

endmodule

/* rtl/core/mlp_ff_ctrl.sv */
// Sequencer: buffer clearing, layer and neuron loops, result hand-off.
`timescale 1ns / 1ps

module mlp_ff_ctrl
   import mlp_ff_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  req_item_type  req_item,
   output logic          req_stall,
   input  cfg_type       cfg,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   localparam int ADEPTH  = 2 * MAX_WIDTH;
   localparam int AADDR_W = $clog2(ADEPTH);

   ctl_state_type        state_ff, state_in;
   logic [AADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [2:0]           layer_ff, layer_in;
   logic [4:0]           neuron_ff, neuron_in;
   logic [4:0]           src_ff, src_in;
   logic                 cur_ff, cur_in;
   logic [4:0]           n_ff, n_in;

   logic                 accept;
   logic                 out_layer;
   logic [4:0]           count;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_layer = (layer_ff == cfg.hidden);
   assign count     = out_layer ? cfg.outs : cfg.per;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         layer_ff   <= '0;
         neuron_ff  <= '0;
         src_ff     <= '0;
         cur_ff     <= 1'b0;
         n_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         layer_ff   <= layer_in;
         neuron_ff  <= neuron_in;
         src_ff     <= src_in;
         cur_ff     <= cur_in;
         n_ff       <= n_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      layer_in   = layer_ff;
      neuron_in  = neuron_ff;
      src_in     = src_ff;
      cur_in     = cur_ff;
      n_in       = n_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (int'(clr_cnt_ff) == ADEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_item.operation == OP_DATA && req_item.last) begin
               if (!status.weights_written) begin
                  state_in = ST_ERROR;
               end else begin
                  layer_in = '0;
                  cur_in   = 1'b0;
                  n_in     = cfg.n_in;
                  state_in = ST_LAYER;
               end
            end
         end
         ST_ERROR: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LAYER: begin
            if (count == 5'd0) begin
               if (out_layer) begin
                  state_in = ST_IDLE;
               end else begin
                  layer_in = layer_ff + 3'd1;
                  cur_in   = ~cur_ff;
                  n_in     = cfg.per;
               end
            end else begin
               neuron_in = '0;
               state_in  = ST_START;
            end
         end
         ST_START: begin
            src_in   = '0;
            state_in = (n_ff == 5'd0) ? ST_DRAIN : ST_MAC;
         end
         ST_MAC: begin
            src_in = src_ff + 5'd1;
            if (src_ff == n_ff - 5'd1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.mac_idle) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_layer || status.rsp_free) begin
               if (neuron_ff == count - 5'd1) begin
                  if (out_layer) begin
                     state_in = ST_IDLE;
                  end else begin
                     layer_in = layer_ff + 3'd1;
                     cur_in   = ~cur_ff;
                     n_in     = cfg.per;
                     state_in = ST_LAYER;
                  end
               end else begin
                  neuron_in = neuron_ff + 5'd1;
                  state_in  = ST_START;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.clear_addr = ABUF_ADDR_MAX_W'(clr_cnt_ff);
      cmd.rd_layer   = layer_ff;
      cmd.rd_neuron  = neuron_ff;
      cmd.rd_src     = src_ff;
      cmd.rd_half    = cur_ff;
      cmd.wr_half    = ~cur_ff;
      cmd.wr_neuron  = neuron_ff;
      cmd.rsp_last   = (neuron_ff == count - 5'd1);
      cmd.req_accept = accept;
      case (state_ff)
         ST_CLEAR:  cmd.clear_en  = 1'b1;
         ST_ERROR:  cmd.load_err  = status.rsp_free;
         ST_START:  cmd.acc_clear = 1'b1;
         ST_MAC:    cmd.issue     = 1'b1;
         ST_FINISH: begin
            cmd.wr_act   = !out_layer;
            cmd.load_rsp = out_layer && status.rsp_free;
         end
         default: ;
      endcase
   end

endmodule

/* rtl/core/mlp_ff_dpath.sv */
// Weight store, activation buffers, multiply-accumulate, activation and result register.
`timescale 1ns / 1ps

module mlp_ff_dpath
   import mlp_ff_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HIDDEN = MAX_HIDDEN_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  req_item_type  req_item,
   input  ctl_cmd_type   cmd,
   input  logic [1:0]    act_mode,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_item_type  rsp_item
);

   localparam int WDEPTH  = (MAX_HIDDEN + 1) * MAX_WIDTH * MAX_WIDTH;
   localparam int WADDR_W = $clog2(WDEPTH);
   localparam int ADEPTH  = 2 * MAX_WIDTH;
   localparam int AADDR_W = $clog2(ADEPTH);
   localparam int ACC_W   = 33 + $clog2(MAX_WIDTH);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

   logic signed [15:0] wmem [WDEPTH];
   logic signed [15:0] amem [ADEPTH];

   logic                      w_we;
   logic [WADDR_W-1:0]        w_waddr;
   logic [WADDR_W-1:0]        w_raddr;
   logic                      a_we;
   logic [AADDR_W-1:0]        a_waddr;
   logic signed [15:0]        a_wdata;
   logic [AADDR_W-1:0]        a_raddr;

   logic signed [15:0]        w_rd_ff;
   logic signed [15:0]        a_rd_ff;
   logic                      rd_v_ff;
   logic signed [31:0]        prod_ff;
   logic                      prod_v_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      ww_ff;
   logic                      rsp_valid_ff;
   rsp_item_type              rsp_item_ff;

   logic signed [ACC_W-1:0]   shifted;
   logic signed [15:0]        sat16;
   logic signed [15:0]        act_val;
   logic                      w_in_range;

   assign w_in_range = (int'(req_item.layer_index) <= MAX_HIDDEN)
                    && (int'(req_item.neuron_index) < MAX_WIDTH)
                    && (int'(req_item.source_index) < MAX_WIDTH);
   assign w_we    = cmd.req_accept && req_item.operation == OP_WEIGHT && w_in_range;
   assign w_waddr = WADDR_W'((int'(req_item.layer_index) * MAX_WIDTH
                     + int'(req_item.neuron_index)) * MAX_WIDTH
                     + int'(req_item.source_index));
   assign w_raddr = WADDR_W'((int'(cmd.rd_layer) * MAX_WIDTH + int'(cmd.rd_neuron))
                     * MAX_WIDTH + int'(cmd.rd_src));
   assign a_raddr = AADDR_W'(int'(cmd.rd_half) * MAX_WIDTH + int'(cmd.rd_src));

   // Saturate the scaled sum and apply the activation.
   always_comb begin
      shifted = acc_ff >>> 8;
      if (shifted > SAT_HI) begin
         sat16 = 16'sh7fff;
      end else if (shifted < SAT_LO) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = shifted[15:0];
      end
      act_val = activate(act_mode, sat16);
   end

   // One write port for the activation buffers: clearing, input items, neuron results.
   always_comb begin
      a_we    = 1'b0;
      a_waddr = '0;
      a_wdata = act_val;
      if (cmd.clear_en) begin
         a_we    = 1'b1;
         a_waddr = cmd.clear_addr[AADDR_W-1:0];
         a_wdata = '0;
      end else if (cmd.wr_act) begin
         a_we    = 1'b1;
         a_waddr = AADDR_W'(int'(cmd.wr_half) * MAX_WIDTH + int'(cmd.wr_neuron));
      end else if (cmd.req_accept && req_item.operation == OP_DATA
                   && int'(req_item.source_index) < MAX_WIDTH) begin
         a_we    = 1'b1;
         a_waddr = AADDR_W'(req_item.source_index);
         a_wdata = req_item.value;
      end
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= req_item.value;
      end
      if (cmd.issue) begin
         w_rd_ff <= wmem[w_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         amem[a_waddr] <= a_wdata;
      end
      if (cmd.issue) begin
         a_rd_ff <= amem[a_raddr];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_rd_ff * w_rd_ff;
      acc_ff  <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (prod_v_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         ww_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.issue;
         prod_v_ff <= rd_v_ff;
         if (w_we) begin
            ww_ff <= 1'b1;
         end
         if (cmd.load_rsp || cmd.load_err) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_err) begin
         rsp_item_ff.output_index <= '0;
         rsp_item_ff.output_value <= '0;
         rsp_item_ff.last_output  <= 1'b1;
         rsp_item_ff.no_weights   <= 1'b1;
      end else if (cmd.load_rsp) begin
         rsp_item_ff.output_index <= cmd.wr_neuron[3:0];
         rsp_item_ff.output_value <= act_val;
         rsp_item_ff.last_output  <= cmd.rsp_last;
         rsp_item_ff.no_weights   <= 1'b0;
      end
   end

   assign status.mac_idle        = !rd_v_ff && !prod_v_ff;
   assign status.rsp_free        = !rsp_valid_ff || !rsp_stall;
   assign status.weights_written = ww_ff;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_item               = rsp_item_ff;

endmodule

/* tb/sv/tb_mlp_feed_forward_top.sv */
// Self-checking testbench for the feed-forward network engine.
`timescale 1ns / 1ps

// Predicts every result item from the accepted items and checks the results in order.
class net_scoreboard;
   shortint            sig_tab[256];
   shortint            tanh_tab[256];
   logic signed [15:0] wts[1280];
   bit                 wr_mask[1280];
   logic signed [15:0] acts[32];
   bit                 any_weight;
   int                 mode;
   int                 n_cfg;
   int                 hid_cfg;
   int                 per_cfg;
   int                 outs_cfg;
   mlp_ff_pkg::rsp_item_type expected_q[$];
   int                 fails;

   function new();
      longint unsigned e_tab[129];
      longint unsigned e, den, num, r, d, t;
      int k;
      e_tab[0] = 64'd16777216;
      for (int i = 1; i <= 128; i++)
         e_tab[i] = (e_tab[i-1] * 64'd17859253 + 64'd8388608) >> 24;
      for (int i = 0; i < 256; i++) begin
         k   = i - 128;
         e   = e_tab[(k < 0) ? -k : k];
         den = e + 64'd16777216;
         num = (k >= 0) ? 256 * e : 256 * 64'd16777216;
         r   = ((64'd1 << 48) + e / 2) / e;
         d   = e + r;
         t   = (2 * 256 * (e - r) + d) / (2 * d);
         sig_tab[i]  = shortint'((2 * num + den) / (2 * den));
         tanh_tab[i] = (k < 0) ? -shortint'(t) : shortint'(t);
      end
      foreach (acts[i]) acts[i] = '0;
      foreach (wts[i]) wts[i] = '0;
      any_weight = 0;
      mode = 0; n_cfg = 16; hid_cfg = 1; per_cfg = 16; outs_cfg = 16;
      fails = 0;
   endfunction

   function int clampv(int v, int hi);
      return (v > hi) ? hi : v;
   endfunction

   function void note_config(logic [2:0] idx, logic [4:0] data);
      case (idx)
         mlp_ff_pkg::CSR_ACT_MODE: mode     = data & 3;
         mlp_ff_pkg::CSR_INPUTS:   n_cfg    = data;
         mlp_ff_pkg::CSR_HIDDEN:   hid_cfg  = data & 7;
         mlp_ff_pkg::CSR_PER_HID:  per_cfg  = data;
         mlp_ff_pkg::CSR_OUTPUTS:  outs_cfg = data;
         default: ;
      endcase
   endfunction

   function logic signed [15:0] squash(logic signed [15:0] s);
      int idx;
      if (mode == mlp_ff_pkg::ACT_RELU) return (s > 0) ? s : 16'sd0;
      idx = ((int'(s) + 32768) >> 4) - 1920;
      if (idx < 0) idx = 0;
      if (idx > 255) idx = 255;
      return (mode == mlp_ff_pkg::ACT_TANH) ? tanh_tab[idx] : sig_tab[idx];
   endfunction

   function logic signed [15:0] neuron_out(int half, int layer, int dst, int n);
      longint acc;
      longint r;
      int     base;
      acc  = 0;
      base = (layer * 16 + dst) * 16;
      for (int k = 0; k < n; k++)
         acc += longint'(acts[half * 16 + k]) * longint'(wts[base + k]);
      r = acc >>> 8;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return squash(16'(r));
   endfunction

   function void note_item(mlp_ff_pkg::req_item_type it);
      int n, h, p, o, cur, addr;
      mlp_ff_pkg::rsp_item_type e;
      if (it.operation == mlp_ff_pkg::OP_WEIGHT) begin
         if (it.layer_index <= 4) begin
            addr = (it.layer_index * 16 + it.neuron_index) * 16 + it.source_index;
            wts[addr]     = it.value;
            wr_mask[addr] = 1;
            any_weight    = 1;
         end
         return;
      end
      acts[it.source_index] = it.value;
      if (!it.last) return;
      if (!any_weight) begin
         e = '0;
         e.last_output = 1;
         e.no_weights  = 1;
         expected_q.push_back(e);
         return;
      end
      n = clampv(n_cfg, 16);
      h = clampv(hid_cfg, 4);
      p = clampv(per_cfg, 16);
      o = clampv(outs_cfg, 16);
      cur = 0;
      for (int l = 0; l < h; l++) begin
         for (int j = 0; j < p; j++)
            acts[(1 - cur) * 16 + j] = neuron_out(cur, l, j, n);
         cur = 1 - cur;
         n   = p;
      end
      for (int j = 0; j < o; j++) begin
         e.output_index = 4'(j);
         e.output_value = neuron_out(cur, h, j, n);
         e.last_output  = (j == o - 1);
         e.no_weights   = 0;
         expected_q.push_back(e);
      end
   endfunction

   function void check_result(mlp_ff_pkg::rsp_item_type got);
      mlp_ff_pkg::rsp_item_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result item %h", $time, got);
         fails++;
         return;
      end
      e = expected_q.pop_front();
      if (got.output_index !== e.output_index) begin
         $display("%0t: output_index expected %0d actual %0d", $time,
                  e.output_index, got.output_index);
         fails++;
      end
      if (got.output_value !== e.output_value) begin
         $display("%0t: output_value expected %0d actual %0d", $time,
                  e.output_value, got.output_value);
         fails++;
      end
      if (got.last_output !== e.last_output) begin
         $display("%0t: last_output expected %0b actual %0b", $time,
                  e.last_output, got.last_output);
         fails++;
      end
      if (got.no_weights !== e.no_weights) begin
         $display("%0t: no_weights expected %0b actual %0b", $time,
                  e.no_weights, got.no_weights);
         fails++;
      end
   endfunction
endclass

module tb_mlp_feed_forward_top;
   import mlp_ff_pkg::*;

   localparam int STALL_LIMIT = 20000;  // cycles with no handshake at all
   localparam int IDLE_GAP    = 1500;   // covers a full run that emits nothing

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [4:0]   csr_wdata;

   net_scoreboard sb;
   bit quiet;         // no idling on either side while set
   bit hold_req;      // ask the receiver for one long hold-off
   int items_sent;
   int idle_cycles;

   mlp_feed_forward_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 0;
   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Weighted value mix: saturation extremes, full-range noise, mostly small Q8.8.
   function automatic logic signed [15:0] rand_value();
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return 16'($urandom);
         default: return 16'($signed($urandom_range(1023)) - 512);
      endcase
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send(req_item_type it);
      if (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_item  <= it;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      sb.note_item(it);
      items_sent++;
   endtask

   task automatic send_weight(int l, int j, int k, logic signed [15:0] v);
      req_item_type it;
      it = '0;
      it.operation    = OP_WEIGHT;
      it.layer_index  = 3'(l);
      it.neuron_index = 4'(j);
      it.source_index = 4'(k);
      it.value        = v;
      it.last         = 1'($urandom_range(1));  // ignored on weights
      send(it);
   endtask

   task automatic send_data(int k, logic signed [15:0] v, bit fin);
      req_item_type it;
      it = '0;
      it.operation    = OP_DATA;
      it.layer_index  = 3'($urandom_range(7));
      it.neuron_index = 4'($urandom_range(15));
      it.source_index = 4'(k);
      it.value        = v;
      it.last         = fin;
      send(it);
   endtask

   // Write all five registers back to back; only called while the block is idle.
   task automatic configure(int m, int n, int h, int p, int o);
      logic [2:0] idx [5];
      int         val [5];
      idx = '{CSR_ACT_MODE, CSR_INPUTS, CSR_HIDDEN, CSR_PER_HID, CSR_OUTPUTS};
      val = '{m, n, h, p, o};
      for (int i = 0; i < 5; i++) begin
         csr_index <= idx[i];
         csr_wdata <= 5'(val[i]);
         csr_we    <= 1;
         @(posedge clock);
         sb.note_config(idx[i], 5'(val[i]));
      end
      csr_we <= 0;
   endtask

   // Load every weight the current setting will read that was never written.
   task automatic fill_weights();
      int n, h, p, o, rows, cols;
      n = sb.clampv(sb.n_cfg, 16);
      h = sb.clampv(sb.hid_cfg, 4);
      p = sb.clampv(sb.per_cfg, 16);
      o = sb.clampv(sb.outs_cfg, 16);
      for (int l = 0; l <= h; l++) begin
         rows = (l < h) ? p : o;
         cols = (l == 0) ? n : p;
         for (int j = 0; j < rows; j++)
            for (int k = 0; k < cols; k++)
               if (!sb.wr_mask[(l * 16 + j) * 16 + k]) send_weight(l, j, k, rand_value());
      end
   endtask

   // One input vector with some elements left out and some noise mixed in.
   task automatic run_vector();
      int n;
      fill_weights();
      n = sb.clampv(sb.n_cfg, 16);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(99) < 12) begin
            if ($urandom_range(1)) send_weight($urandom_range(7), $urandom_range(15),
                                               $urandom_range(15), rand_value());
            else send_data($urandom_range(15), rand_value(), 1'b0);
         end
         if ($urandom_range(99) < 90) send_data(k, rand_value(), 1'b0);
      end
      send_data($urandom_range(15), rand_value(), 1'b1);
   endtask

   // Pause the sender until every result item is in, then let the block settle.
   task automatic wait_idle();
      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   // Receiver: check each accepted result, stall at random or for one long hold.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_item);
         if (hold_req) begin
            hold_req  = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 8);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int o;
      sb          = new();
      reset       = 1;
      req_valid   = 0;
      req_item    = '0;
      csr_we      = 0;
      csr_index   = '0;
      csr_wdata   = '0;
      quiet       = 0;
      hold_req    = 0;
      items_sent  = 0;
      idle_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // Out-of-range layer is dropped, so a run still reports missing weights.
      send_weight(7, 15, 15, -1);
      send_data(15, 16'sh7FFF, 1'b1);
      wait_idle();

      // Input extremes through a single sigmoid layer.
      configure(ACT_SIGMOID, 2, 0, 1, 2);
      fill_weights();
      send_data(0, 16'sh7FFF, 1'b0);
      send_data(1, 16'sh8000, 1'b1);
      wait_idle();

      configure(ACT_RELU, 1, 1, 1, 1);
      run_vector();
      wait_idle();
      configure(ACT_TANH, 3, 2, 2, 3);
      run_vector();
      run_vector();
      wait_idle();
      configure(3, 2, 3, 2, 2);          // reserved mode behaves as sigmoid
      run_vector();
      wait_idle();
      configure(ACT_RELU, 0, 1, 0, 2);   // empty sums everywhere
      run_vector();
      wait_idle();
      configure(ACT_SIGMOID, 2, 1, 2, 0); // run that emits nothing
      run_vector();
      wait_idle();
      configure(ACT_TANH, 31, 7, 2, 31); // oversized counts clamp
      run_vector();
      wait_idle();

      // Long stretch with no idling on either side.
      quiet = 1;
      configure(ACT_RELU, 16, 0, 16, 16);
      run_vector();
      wait_idle();
      quiet = 0;

      // Back-pressure: hold results while the sender keeps offering runs.
      configure(ACT_RELU, 2, 0, 2, 4);
      fill_weights();
      hold_req = 1;
      repeat (6) run_vector();
      wait_idle();

      // Random settings, mostly small.
      while (items_sent < 450) begin
         o = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 6);
         if ($urandom_range(7) == 0)
            configure($urandom_range(3), $urandom_range(31), $urandom_range(7),
                      $urandom_range(31), o);
         else
            configure($urandom_range(3), $urandom_range(1, 6), $urandom_range(2),
                      $urandom_range(1, 6), o);
         quiet = ($urandom_range(9) == 0);
         repeat ($urandom_range(2, 5)) run_vector();
         wait_idle();
         quiet = 0;
      end

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.fails == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/mlp_ff_pkg.sv
rtl/core/mlp_ff_csr.sv
rtl/core/mlp_ff_ctrl.sv
rtl/core/mlp_ff_dpath.sv
rtl/core/mlp_feed_forward_top.sv
tb/sv/tb_mlp_feed_forward_top.sv
